FILE: rtl/core/dqu_pkg.sv
// shared types and constants for the double-ended queue unit
// used by dqu_ram, dqu_ctrl, double_ended_queue_unit and dqu_checker
package dqu_pkg;

  // queue geometry; count field is 7 bits, so the depth is fixed here
  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] EMPTY_DATA = '1;

  // command codes
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // input transaction
  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
  } out_item_t;

  // store access request from control to memory
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

  // registered result waiting for the memory read data
  typedef struct packed {
    logic                     valid;
    logic                     use_mem;
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic [CNT_W-1:0]         count;
  } rsp_t;

endpackage

FILE: rtl/core/double_ended_queue_unit.sv
// Double-ended queue of 64 signed 32-bit words in a ring store. A transaction
// is taken at each clock edge with start high and busy low; busy is never
// raised, so a command may be issued every cycle. Each transaction returns one
// result in the next cycle, shown for that single cycle with out_valid
// high; the receiver has no way to hold it. The result register is aligned with
// the registered read of the ring store, which each command touches at most once.
// Pops and peeks on an empty queue return -1 with status empty; a push to a
// full queue is dropped with status full. No clearing pass follows reset.
// depends on dqu_pkg, dqu_ctrl, dqu_ram
module double_ended_queue_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dqu_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dqu_pkg::out_item_t out_item
);
  import dqu_pkg::*;

  logic              accept;
  mem_req_t          req;
  rsp_t              rsp;
  logic [DATA_W-1:0] rd_data;

  // every command needs at most one store access, so there is no stall
  assign busy   = 1'b0;
  assign accept = start && !busy;

  dqu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .req     (req),
    .rsp     (rsp)
  );

  dqu_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // result: store data for successful pops and peeks, fixed data otherwise
  assign out_valid       = rsp.valid;
  assign out_item.data   = rsp.use_mem ? $signed(rd_data) : rsp.data;
  assign out_item.status = rsp.status;
  assign out_item.count  = rsp.count;

endmodule

FILE: rtl/core/dqu_ram.sv
// ring store: one write port and one read port, registered read data
// depends on dqu_pkg
module dqu_ram (
  input  logic                      clk,
  input  dqu_pkg::mem_req_t         req,
  output logic [dqu_pkg::DATA_W-1:0] rd_data
);
  import dqu_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/dqu_ctrl.sv
// pointer and count control: decodes commands, issues store accesses,
// registers the pending result; depends on dqu_pkg
module dqu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  dqu_pkg::in_item_t in_item,
  output dqu_pkg::mem_req_t req,
  output dqu_pkg::rsp_t     rsp
);
  import dqu_pkg::*;

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  rsp_t             rsp_r, rsp_nxt;

  logic             full;
  logic             empty;
  logic [PTR_W-1:0] front_inc, front_dec;
  logic [PTR_W-1:0] back_inc, back_dec;

  // occupancy flags and wrapped neighbors of each pointer
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + PTR_W'(1);
  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
  assign back_inc  = (back_r == PTR_W'(DEPTH - 1)) ? '0 : back_r + PTR_W'(1);
  assign back_dec  = (back_r == '0) ? PTR_W'(DEPTH - 1) : back_r - PTR_W'(1);

  // command decode
  always_comb begin
    front_nxt       = front_r;
    back_nxt        = back_r;
    count_nxt       = count_r;
    req             = '0;
    rsp_nxt.valid   = accept;
    rsp_nxt.use_mem = 1'b0;
    rsp_nxt.data    = '0;
    rsp_nxt.status  = ST_OK;
    if (accept) begin
      unique case (in_item.command)
        CMD_PUSH_FRONT: begin
          if (full) begin
            rsp_nxt.status = ST_FULL;
          end else begin
            front_nxt = front_dec;
            req.we    = 1'b1;
            req.waddr = front_dec;
            req.wdata = in_item.value;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            rsp_nxt.status = ST_FULL;
          end else begin
            back_nxt  = back_inc;
            req.we    = 1'b1;
            req.waddr = back_r;
            req.wdata = in_item.value;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
          if (empty) begin
            rsp_nxt.data   = EMPTY_DATA;
            rsp_nxt.status = ST_EMPTY;
          end else begin
            req.re          = 1'b1;
            rsp_nxt.use_mem = 1'b1;
            unique case (in_item.command)
              CMD_POP_FRONT: begin
                req.raddr = front_r;
                front_nxt = front_inc;
                count_nxt = count_r - CNT_W'(1);
              end
              CMD_POP_BACK: begin
                req.raddr = back_dec;
                back_nxt  = back_dec;
                count_nxt = count_r - CNT_W'(1);
              end
              CMD_PEEK_FRONT: begin
                req.raddr = front_r;
              end
              default: begin
                req.raddr = back_dec;
              end
            endcase
          end
        end
        default: begin
          // unknown command: result only
        end
      endcase
    end
    rsp_nxt.count = count_nxt;
  end

  // pointer, count and result registers; result payload is aligned with
  // the store read data and needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r       <= '0;
      back_r        <= '0;
      count_r       <= '0;
      rsp_r.valid   <= 1'b0;
    end else begin
      front_r       <= front_nxt;
      back_r        <= back_nxt;
      count_r       <= count_nxt;
      rsp_r.valid   <= rsp_nxt.valid;
    end
    rsp_r.use_mem <= rsp_nxt.use_mem;
    rsp_r.data    <= rsp_nxt.data;
    rsp_r.status  <= rsp_nxt.status;
    rsp_r.count   <= rsp_nxt.count;
  end

  assign rsp = rsp_r;

endmodule

FILE: rtl/core/dqu_checker.sv
// port-level checks for double_ended_queue_unit, attached by bind
// depends on dqu_pkg
module dqu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input dqu_pkg::out_item_t out_item
);
  import dqu_pkg::*;

  // each accepted transaction gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction produced no result");

  // no result without a transaction in the previous cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a transaction");

  // count moves by at most one between back-to-back results
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |->
      (out_item.count == $past(out_item.count)) ||
      (out_item.count == $past(out_item.count) + CNT_W'(1)) ||
      (out_item.count == $past(out_item.count) - CNT_W'(1)))
    else $error("count jumped by more than one");

  // an empty result carries -1 and a zero count
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY) |->
      (out_item.data == EMPTY_DATA) && (out_item.count == '0))
    else $error("empty status with wrong data or count");

  // a dropped push reports a full queue and zero data
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |->
      (out_item.data == '0) && (out_item.count == CNT_W'(DEPTH)))
    else $error("full status with wrong data or count");

endmodule

bind double_ended_queue_unit dqu_checker u_dqu_checker (.*);
